>>> sv/base64_strict_decoder_macros.svh
// ---------------------------------------------------------------------------
// base64 strict decoder assertion macros
// Shared property macros for the decoder's port checker.
// ---------------------------------------------------------------------------
`ifndef BASE64_STRICT_DECODER_MACROS_SVH
`define BASE64_STRICT_DECODER_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define B64SD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while rst is high
`define B64SD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/b64sd_pkg.sv
// ---------------------------------------------------------------------------
// base64 strict decoder package
// Payload types for both channels and the job record passed front to back.
// ---------------------------------------------------------------------------
package b64sd_pkg;

   // one input text character
   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_error;
      logic       run_last;
      logic       text_done;
   } rsp_type;

   // index of the last byte of a job (one to three bytes)
   localparam int unsigned ByteIdxWidth = 2;

   // work item for the back end: a full group or an error
   typedef struct packed {
      logic [23:0]             packed_bytes;
      logic [ByteIdxWidth-1:0] last_idx;
      logic                    is_error;
      logic                    text_done;
   } job_type;

endpackage

>>> sv/b64sd_front.sv
// ---------------------------------------------------------------------------
// b64sd front end
// Classifies each character, tracks the group and discard state, and forms
// one job per completed group or per error.
// ---------------------------------------------------------------------------
module b64sd_front
   import b64sd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job
);

   localparam logic [7:0] CharPad   = 8'h3D;  // '='
   localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
   localparam logic [7:0] CharSlash = 8'h2F;  // '/'
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoZ   = 8'h7A;
   localparam logic [7:0] CharDig0  = 8'h30;
   localparam logic [7:0] CharDig9  = 8'h39;
   localparam logic [7:0] OffsetLo  = 8'd26;
   localparam logic [7:0] OffsetDig = 8'd52;
   localparam logic [5:0] SextetPlus  = 6'd62;
   localparam logic [5:0] SextetSlash = 6'd63;

   // group state
   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic        tpad_ff, tpad_in;
   logic        disc_ff, disc_in;

   // character classification
   logic [7:0] ch;
   logic       fin;
   logic       is_pad;
   logic       bad_char;
   logic [7:0] sx_wide;
   logic [5:0] sx;
   logic [5:0] sx_pad0;

   // job helpers
   logic       raise_error;
   logic       emit_group;
   logic [1:0] emit_last;

   assign ch     = req_data.char_code;
   assign fin    = req_data.final_char;
   assign is_pad = (ch == CharPad);

   // alphabet lookup
   always_comb begin
      bad_char = 1'b0;
      sx_wide  = 8'd0;
      priority if (ch >= CharUpA && ch <= CharUpZ) begin
         sx_wide = ch - CharUpA;
      end else if (ch >= CharLoA && ch <= CharLoZ) begin
         sx_wide = ch - CharLoA + OffsetLo;
      end else if (ch >= CharDig0 && ch <= CharDig9) begin
         sx_wide = ch - CharDig0 + OffsetDig;
      end else if (ch == CharPlus) begin
         sx_wide = {2'b00, SextetPlus};
      end else if (ch == CharSlash) begin
         sx_wide = {2'b00, SextetSlash};
      end else begin
         bad_char = 1'b1;
      end
   end

   assign sx      = sx_wide[5:0];
   assign sx_pad0 = is_pad ? 6'd0 : sx;

   // group sequencing and checks
   always_comb begin
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      tpad_in     = tpad_ff;
      disc_in     = disc_ff;
      raise_error = 1'b0;
      emit_group  = 1'b0;
      emit_last   = 2'd2;
      if (accept) begin
         if (disc_ff) begin
            // drop the rest of a failed text up to its final character
            if (fin) begin
               disc_in = 1'b0;
               pos_in  = 2'd0;
               acc_in  = 18'd0;
               tpad_in = 1'b0;
            end
         end else begin
            unique case (pos_ff)
               2'd0, 2'd1: begin
                  if (bad_char || fin) begin
                     raise_error = 1'b1;
                  end else begin
                     acc_in = {acc_ff[11:0], sx};
                     pos_in = pos_ff + 2'd1;
                  end
               end
               2'd2: begin
                  if (fin || (bad_char && !is_pad)) begin
                     raise_error = 1'b1;
                  end else begin
                     tpad_in = is_pad;
                     acc_in  = {acc_ff[11:0], sx_pad0};
                     pos_in  = 2'd3;
                  end
               end
               2'd3: begin
                  if (is_pad ? !fin : (bad_char || tpad_ff)) begin
                     raise_error = 1'b1;
                  end else begin
                     emit_group = 1'b1;
                     emit_last  = tpad_ff ? 2'd0 : (is_pad ? 2'd1 : 2'd2);
                     pos_in     = 2'd0;
                     acc_in     = 18'd0;
                     tpad_in    = 1'b0;
                  end
               end
               default: begin
                  raise_error = 1'b1;
               end
            endcase
            // an error clears the group and may start discarding
            if (raise_error) begin
               pos_in  = 2'd0;
               acc_in  = 18'd0;
               tpad_in = 1'b0;
               disc_in = !fin;
            end
         end
      end
   end

   // job record
   always_comb begin
      job_valid = raise_error || emit_group;
      if (raise_error) begin
         job.packed_bytes = 24'd0;
         job.last_idx     = 2'd0;
         job.is_error     = 1'b1;
         job.text_done    = 1'b1;
      end else begin
         job.packed_bytes = {acc_ff, sx_pad0};
         job.last_idx     = emit_last;
         job.is_error     = 1'b0;
         job.text_done    = fin;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         acc_ff  <= 18'd0;
         tpad_ff <= 1'b0;
         disc_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         tpad_ff <= tpad_in;
         disc_ff <= disc_in;
      end
   end

endmodule

>>> sv/b64sd_queue.sv
// ---------------------------------------------------------------------------
// b64sd job queue
// Small first-in first-out store of jobs between the front and back ends.
// ---------------------------------------------------------------------------
module b64sd_queue
   import b64sd_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   job_type              slots_ff [DEPTH];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 do_wr;
   logic                 do_rd;

   assign full   = (cnt_ff == FullCnt);
   assign empty  = (cnt_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = slots_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

>>> sv/b64sd_back.sv
// ---------------------------------------------------------------------------
// b64sd back end
// Walks the bytes of the oldest job, one result per transfer, and retires
// the job after its last byte.
// ---------------------------------------------------------------------------
module b64sd_back
   import b64sd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    head_valid,
   input  logic    pop,
   output rsp_type rsp_data,
   output logic    retire
);

   logic [ByteIdxWidth-1:0] idx_ff, idx_in;
   logic                    at_last;
   logic                    xfer;

   assign at_last = (idx_ff == head.last_idx);
   assign xfer    = pop && head_valid;
   assign retire  = xfer && at_last;

   // byte select and flags
   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_data.out_byte = head.packed_bytes[23:16];
         2'd1:    rsp_data.out_byte = head.packed_bytes[15:8];
         2'd2:    rsp_data.out_byte = head.packed_bytes[7:0];
         default: rsp_data.out_byte = 8'd0;
      endcase
      rsp_data.is_error  = head.is_error;
      rsp_data.run_last  = at_last;
      rsp_data.text_done = at_last && head.text_done;
   end

   // byte index within the current job
   always_comb begin
      idx_in = idx_ff;
      if (retire) begin
         idx_in = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> sv/base64_strict_decoder.sv
// ---------------------------------------------------------------------------
// base64 strict decoder
// Streaming RFC 4648 base64 decoder with strict padding and length checks.
//
//   channel   ports                        transfer when
//   input     push, full, req_data         push && !full
//   result    empty, pop, rsp_data         pop && !empty
//
// One character is taken per cycle while the job queue has room.
// A completed group or an error becomes one queued job; the back end sends
// one to three results from it, one per cycle while pop is high.
// full rises only when all QUEUE_DEPTH job slots hold unfinished jobs.
// Reset is synchronous and clears the group state, queue and byte index.
// ---------------------------------------------------------------------------
module base64_strict_decoder
   import b64sd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    job_valid;
   job_type job;
   job_type head;
   logic    retire;

   assign accept = push && !full;

   // character classification and group tracking
   b64sd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job)
   );

   // jobs waiting for the back end
   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_valid),
      .wr_job (job),
      .rd_en  (retire),
      .rd_job (head),
      .full   (full),
      .empty  (empty)
   );

   // result sequencing
   b64sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .retire     (retire)
   );

endmodule

>>> sv/b64sd_checker.sv
// ---------------------------------------------------------------------------
// b64sd port checker
// Watches the decoder ports for result formatting and ordering slips.
// ---------------------------------------------------------------------------
`include "base64_strict_decoder_macros.svh"

module b64sd_checker
   import b64sd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // error results carry a zero byte and close the text
   `B64SD_ASSERT_NOW(a_error_form, clock, reset, !empty && rsp_data.is_error, rsp_data.out_byte == 8'd0 && rsp_data.run_last && rsp_data.text_done, "error result malformed")

   // end of text only on the last result of a job
   `B64SD_ASSERT_NOW(a_done_is_last, clock, reset, !empty && rsp_data.text_done, rsp_data.run_last, "text_done without run_last")

   // a job's remaining results follow without a gap
   `B64SD_ASSERT_NEXT(a_run_continues, clock, reset, !empty && !rsp_data.run_last, !empty, "result run broken")

   // reset leaves nothing to deliver and room to accept
   `B64SD_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, empty && !full, "not clear after reset")

   // a waiting result holds until taken
   `B64SD_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data), "result changed while waiting")

endmodule

bind base64_strict_decoder b64sd_checker u_b64sd_checker (.*);

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// base64 strict decoder testbench
// Feeds base64 text one character per transfer and checks every decoded
// byte and error result against a local decoder model. Short directed texts
// hit the padding, length and bad-character rules, then random texts follow,
// mostly well formed with some corrupted, under random push and pop gaps.
// ---------------------------------------------------------------------------
module tb;
   import b64sd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] PAD_CHAR    = 8'd61;    // '='
   localparam logic [6:0] NOT_BASE64  = 7'd64;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         MAX_REPORTS = 10;

   // one character waiting to be sent
   typedef struct {
      req_type req;
      bit      hold_for_drain;
   } char_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   char_slot_type pending_chars[$];
   rsp_type       expected_bytes[$];

   // decoder model state
   logic [1:0]  group_pos = '0;
   logic [17:0] sextet_bits = '0;
   logic        third_pad = 1'b0;
   logic        dropping = 1'b0;

   int chars_sent = 0;
   int results_predicted = 0;
   int results_seen = 0;
   int errors_seen = 0;
   int mismatch_count = 0;
   int texts_queued = 0;
   int random_chars = 0;
   int cycle_count = 0;

   base64_strict_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // alphabet lookup, NOT_BASE64 for anything else
   function automatic logic [6:0] sextet_value(logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
      if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
      if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
      if (ch == "+") return 7'd62;
      if (ch == "/") return 7'd63;
      return NOT_BASE64;
   endfunction

   function automatic logic [7:0] sextet_char(int unsigned idx);
      if (idx < 26) return 8'("A" + idx);
      if (idx < 52) return 8'("a" + idx - 26);
      if (idx < 62) return 8'("0" + idx - 52);
      if (idx == 62) return "+";
      return "/";
   endfunction

   task automatic expect_result(logic [7:0] value, logic err, logic last, logic done);
      rsp_type r;
      r.out_byte  = value;
      r.is_error  = err;
      r.run_last  = last;
      r.text_done = done;
      expected_bytes = {expected_bytes, r};
      results_predicted++;
   endtask

   // error result; a non-final character starts dropping the rest of the text
   task automatic flag_bad_text(logic fin);
      group_pos   = '0;
      sextet_bits = '0;
      third_pad   = 1'b0;
      dropping    = !fin;
      expect_result(8'd0, 1'b1, 1'b1, 1'b1);
   endtask

   // decoder model: one accepted character in, expected results queued
   task automatic predict_char(req_type c);
      logic [6:0]  sx;
      logic        pad;
      logic        fin;
      logic [23:0] group_bits;
      int          count;
      int          k;
      sx  = sextet_value(c.char_code);
      pad = (c.char_code == PAD_CHAR);
      fin = c.final_char;
      if (dropping) begin
         if (fin) begin
            dropping    = 1'b0;
            group_pos   = '0;
            sextet_bits = '0;
            third_pad   = 1'b0;
         end
      end else if (group_pos < 2) begin
         if (sx == NOT_BASE64 || fin) begin
            flag_bad_text(fin);
         end else begin
            sextet_bits = {sextet_bits[11:0], sx[5:0]};
            group_pos   = group_pos + 2'd1;
         end
      end else if (group_pos == 2) begin
         if (fin || (!pad && sx == NOT_BASE64)) begin
            flag_bad_text(fin);
         end else begin
            if (pad) third_pad = 1'b1;
            sextet_bits = {sextet_bits[11:0], pad ? 6'd0 : sx[5:0]};
            group_pos   = 2'd3;
         end
      end else begin
         // fourth character closes the group
         if (pad ? !fin : (sx == NOT_BASE64 || third_pad)) begin
            flag_bad_text(fin);
         end else begin
            group_bits = {sextet_bits, pad ? 6'd0 : sx[5:0]};
            count = third_pad ? 1 : (pad ? 2 : 3);
            for (k = 0; k < count; k++) begin
               expect_result(group_bits[23 - 8*k -: 8], 1'b0, k == count - 1,
                             (k == count - 1) && fin);
            end
            group_pos   = '0;
            sextet_bits = '0;
            third_pad   = 1'b0;
         end
      end
   endtask

   task automatic add_char(logic [7:0] ch, bit fin, bit hold);
      char_slot_type s;
      s.req.char_code  = ch;
      s.req.final_char = fin;
      s.hold_for_drain = hold;
      pending_chars = {pending_chars, s};
   endtask

   task automatic add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
      texts_queued++;
   endtask

   // random text: mostly well formed, a quarter corrupted in one way
   task automatic add_random_text(bit hold_first);
      logic [7:0] body[$];
      int         groups;
      int         spot;
      int         i;
      int         pad_mode;
      groups = $urandom_range(3, 1);
      for (i = 0; i < groups * 4; i++) body = {body, sextet_char($urandom_range(63))};
      pad_mode = $urandom_range(2);
      if (pad_mode >= 1) body[body.size() - 1] = PAD_CHAR;
      if (pad_mode == 2) body[body.size() - 2] = PAD_CHAR;
      if ($urandom_range(99) >= 75) begin
         spot = $urandom_range(body.size() - 1);
         case ($urandom_range(4))
            0: body[spot] = 8'($urandom_range(255));
            1: repeat ($urandom_range(3, 1)) void'(body.pop_back());
            2: body[spot] = PAD_CHAR;
            3: repeat ($urandom_range(3, 1)) body = {body, sextet_char($urandom_range(63))};
            default: begin
               body.delete();
               repeat ($urandom_range(6, 1)) body = {body, 8'($urandom_range(255))};
            end
         endcase
      end
      for (i = 0; i < body.size(); i++) begin
         add_char(body[i], i == body.size() - 1, hold_first && i == 0);
      end
      random_chars += body.size();
      texts_queued++;
   endtask

   // input driver: predict on each transfer, then offer the next character
   always @(posedge clock) begin : char_driver
      bit sent_now;
      bit hold_off;
      if (reset) begin
         push <= 1'b0;
      end else begin
         sent_now = push && !full;
         if (sent_now) begin
            predict_char(req_data);
            void'(pending_chars.pop_front());
            chars_sent++;
         end
         hold_off = ($urandom_range(99) < 16) && !(chars_sent >= 60 && chars_sent < 100);
         // wait for every outstanding result before a marked character
         if (pending_chars.size() != 0 && pending_chars[0].hold_for_drain &&
             results_predicted - results_seen - int'(pop && !empty) != 0) begin
            hold_off = 1'b1;
         end
         if (pending_chars.size() != 0 && !hold_off) begin
            push     <= 1'b1;
            req_data <= pending_chars[0].req;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin : byte_monitor
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen <= results_seen + 1;
            if (rsp_data.is_error) errors_seen++;
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result: byte %02h err %0b last %0b done %0b",
                           rsp_data.out_byte, rsp_data.is_error, rsp_data.run_last,
                           rsp_data.text_done);
               end
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.is_error !== want.is_error ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.text_done !== want.text_done) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch at result %0d: expected byte %02h err %0b last %0b done %0b",
                              results_seen, want.out_byte, want.is_error, want.run_last,
                              want.text_done);
                     $display("   got byte %02h err %0b last %0b done %0b",
                              rsp_data.out_byte, rsp_data.is_error, rsp_data.run_last,
                              rsp_data.text_done);
                  end
               end
            end
         end
         pop <= ($urandom_range(99) >= 16) || (results_seen >= 20 && results_seen < 50);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d characters unsent, %0d results outstanding",
                  pending_chars.size(), expected_bytes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      // directed texts
      add_text("////ABC=x");            // full bytes, pad fourth mid-text, dropped tail
      add_text("//==");                 // one byte, leftover pad bits ignored
      add_text("+//=");                 // two bytes, plus and slash
      add_char(PAD_CHAR, 1'b0, 1'b0);   // pad in first position
      add_char(8'hFF, 1'b0, 1'b0);
      add_char("B", 1'b1, 1'b0);
      texts_queued++;
      add_text("AB");                   // final mark too early
      add_text("AB=A");                 // pad third, data fourth
      // random texts, a few of them wait for the result side to empty first
      while (random_chars < 95) add_random_text(texts_queued == 6 || texts_queued == 18);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d characters in %0d texts (%0d random characters)",
               chars_sent, texts_queued, random_chars);
      $display("checked %0d results, %0d of them error results, %0d mismatches",
               results_seen, errors_seen, mismatch_count);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
